### rtl/clsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants, command struct and modular fold function shared by the
// combined generator controller, datapath and top level.
// ----------------------------------------------------------------------------
package clsr_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int WARMUP     = 8;

    localparam int VAL_W  = 31;
    localparam int MUL_W  = 16;
    localparam int PROD_W = VAL_W + MUL_W;
    localparam int FOLD_W = 8;
    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + WARMUP);
    localparam int Q_W    = SLOT_W + 2;

    localparam logic [31:0] MOD1       = 32'd2147483563;
    localparam logic [31:0] MOD2       = 32'd2147483399;
    localparam logic [31:0] MOD1_LESS1 = MOD1 - 32'd1;
    localparam logic [MUL_W-1:0] MUL1  = 16'd40014;
    localparam logic [MUL_W-1:0] MUL2  = 16'd40692;

    // 2^31 reduced modulo each modulus
    localparam logic [FOLD_W-1:0] FOLD1 = FOLD_W'(64'h8000_0000 - 64'(MOD1));
    localparam logic [FOLD_W-1:0] FOLD2 = FOLD_W'(64'h8000_0000 - 64'(MOD2));

    localparam logic [VAL_W-1:0] SEED2 = 31'd123456789;

    localparam logic [31:0] SLOT_DIV = 32'd1 + MOD1_LESS1 / 32'(TABLE_SIZE);
    localparam logic [Q_W-1:0] RECIP = Q_W'(64'h8000_0000 / 64'(SLOT_DIV));

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             fold_x;
        logic             fold_sg;
        logic             tbl_wr;
        logic             ld_wr;
        logic [CNT_W-1:0] idx;
        logic             slot_calc;
        logic             finish;
    } clsr_cmd_t;

    // p mod m, with c = 2^31 mod m and p below 2^(31+16)
    function automatic logic [VAL_W-1:0] lehmer_fold(
        input logic [PROD_W-1:0] p,
        input logic [FOLD_W-1:0] c,
        input logic [31:0]       m
    );
        logic [MUL_W+FOLD_W-1:0] hc;
        logic [31:0]             s;
        hc = (MUL_W+FOLD_W)'(p[PROD_W-1:VAL_W]) * (MUL_W+FOLD_W)'(c);
        s  = 32'(p[VAL_W-1:0]) + 32'(hc);
        if (s >= m)
        begin
            s = s - m;
        end
        return s[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/clsr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_ctrl
// Sequencer for load, warm-up steps, draw steps and the output register
// handshake.
// ----------------------------------------------------------------------------
module clsr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire logic                need_reseed,
    output clsr_pkg::clsr_cmd_t      ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_W_MUL,
        ST_W_FOLD,
        ST_D_MUL,
        ST_D_RED,
        ST_D_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [clsr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    if (need_reseed)
                    begin
                        cnt_next   = clsr_pkg::CNT_W'(clsr_pkg::TABLE_SIZE
                                                      + clsr_pkg::WARMUP - 1);
                        state_next = ST_W_MUL;
                    end
                    else
                    begin
                        state_next = ST_D_MUL;
                    end
                end
            end
            ST_W_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_W_FOLD;
            end
            ST_W_FOLD:
            begin
                ctl.fold_x = 1'b1;
                ctl.idx    = cnt_reg;
                ctl.tbl_wr = cnt_reg < clsr_pkg::CNT_W'(clsr_pkg::TABLE_SIZE);
                ctl.ld_wr  = cnt_reg == '0;
                if (cnt_reg == '0)
                begin
                    state_next = ST_D_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - clsr_pkg::CNT_W'(1);
                    state_next = ST_W_MUL;
                end
            end
            ST_D_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = ST_D_RED;
            end
            ST_D_RED:
            begin
                ctl.fold_x    = 1'b1;
                ctl.fold_sg   = 1'b1;
                ctl.slot_calc = 1'b1;
                state_next    = ST_D_OUT;
            end
            ST_D_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

    a_reseed_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && need_reseed) |=>
        (state_reg == ST_W_MUL && cnt_reg == clsr_pkg::CNT_W'(clsr_pkg::TABLE_SIZE
                                                             + clsr_pkg::WARMUP - 1)))
        else $error("reseed did not start the warm-up sequence");

    a_warm_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W_FOLD && cnt_reg == '0) |=> state_reg == ST_D_MUL)
        else $error("warm-up did not hand over to the draw");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished draw not presented");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_D_OUT && out_valid_reg && !out_ready) |=>
        state_reg == ST_D_OUT)
        else $error("draw overwrote a pending result");

endmodule
`default_nettype wire

### rtl/clsr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_dp
// Generator state, shared multiply and fold unit, slot divider and
// shuffle table.
// ----------------------------------------------------------------------------
module clsr_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire clsr_pkg::clsr_cmd_t            ctl,
    input  wire logic                           cmd,
    input  wire logic signed [31:0]             seed_value,
    output logic                                need_reseed,
    output logic [clsr_pkg::VAL_W-1:0]          draw,
    output logic [clsr_pkg::VAL_W-1:0]          first_gen_value
);

    localparam int VAL_W  = clsr_pkg::VAL_W;
    localparam int PROD_W = clsr_pkg::PROD_W;
    localparam int Q_W    = clsr_pkg::Q_W;
    localparam int SLOT_W = clsr_pkg::SLOT_W;
    localparam int TS     = clsr_pkg::TABLE_SIZE;

    logic [VAL_W-1:0]  fg_reg, sg_reg, ld_reg, x_reg;
    logic [VAL_W-1:0]  shuf_reg [TS];
    logic [PROD_W-1:0] p1_reg, p2_reg;
    logic [Q_W-1:0]    q_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  draw_reg, fgv_reg;

    logic [31:0]            seed_neg;
    logic [VAL_W-1:0]       seed_mag, reseed_val, plain_val;
    logic [VAL_W-1:0]       x_fold, sg_fold;
    logic [VAL_W+Q_W-1:0]   q_prod;
    logic [Q_W+31:0]        thr;
    logic [Q_W-1:0]         q_fix;
    logic [SLOT_W-1:0]      slot_next;
    logic [32:0]            diff;
    logic [32:0]            y_sum;
    logic [VAL_W-1:0]       y;

    // magnitude of a nonpositive seed, 1 for zero, saturated for the most negative
    always_comb
    begin
        seed_neg = 32'(-seed_value);
        if (seed_value == 32'sd0)
        begin
            seed_mag = VAL_W'(1);
        end
        else if (seed_neg[31])
        begin
            seed_mag = {VAL_W{1'b1}};
        end
        else
        begin
            seed_mag = seed_neg[VAL_W-1:0];
        end
        need_reseed = cmd ? (fg_reg == '0) : (seed_value[31] || seed_value == 32'sd0);
        reseed_val  = cmd ? VAL_W'(1) : seed_mag;
        plain_val   = cmd ? fg_reg : seed_value[VAL_W-1:0];
    end

    assign x_fold  = clsr_pkg::lehmer_fold(p1_reg, clsr_pkg::FOLD1, clsr_pkg::MOD1);
    assign sg_fold = clsr_pkg::lehmer_fold(p2_reg, clsr_pkg::FOLD2, clsr_pkg::MOD2);

    // slot estimate by reciprocal, then one correction step
    assign q_prod = (VAL_W+Q_W)'(ld_reg) * (VAL_W+Q_W)'(clsr_pkg::RECIP);

    always_comb
    begin
        thr   = ((Q_W+32)'(q_reg) + (Q_W+32)'(1)) * (Q_W+32)'(clsr_pkg::SLOT_DIV);
        q_fix = ((Q_W+32)'(ld_reg) >= thr) ? q_reg + Q_W'(1) : q_reg;
        if (q_fix >= Q_W'(TS))
        begin
            slot_next = SLOT_W'(TS - 1);
        end
        else
        begin
            slot_next = q_fix[SLOT_W-1:0];
        end
    end

    always_comb
    begin
        diff  = {2'b00, shuf_reg[slot_reg]} - {2'b00, sg_reg};
        y_sum = diff;
        if (diff[32] || diff == '0)
        begin
            y_sum = diff + {1'b0, clsr_pkg::MOD1_LESS1};
        end
        y = y_sum[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= '0;
            sg_reg <= clsr_pkg::SEED2;
            ld_reg <= '0;
            for (int i = 0; i < TS; i++)
            begin
                shuf_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.load && need_reseed)
            begin
                sg_reg <= reseed_val;
            end
            else if (ctl.fold_sg)
            begin
                sg_reg <= sg_fold;
            end
            if (ctl.ld_wr)
            begin
                ld_reg <= x_fold;
            end
            else if (ctl.finish)
            begin
                ld_reg <= y;
            end
            if (ctl.tbl_wr)
            begin
                shuf_reg[ctl.idx[SLOT_W-1:0]] <= x_fold;
            end
            else if (ctl.finish)
            begin
                shuf_reg[slot_reg] <= x_reg;
            end
            if (ctl.finish)
            begin
                fg_reg <= x_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg <= need_reseed ? reseed_val : plain_val;
        end
        else if (ctl.fold_x)
        begin
            x_reg <= x_fold;
        end
        if (ctl.mul)
        begin
            p1_reg <= PROD_W'(x_reg) * PROD_W'(clsr_pkg::MUL1);
            p2_reg <= PROD_W'(sg_reg) * PROD_W'(clsr_pkg::MUL2);
            q_reg  <= q_prod[VAL_W+Q_W-1:VAL_W];
        end
        if (ctl.slot_calc)
        begin
            slot_reg <= slot_next;
        end
        if (ctl.finish)
        begin
            draw_reg <= y;
            fgv_reg  <= x_reg;
        end
    end

    assign draw            = draw_reg;
    assign first_gen_value = fgv_reg;

endmodule
`default_nettype wire

### rtl/combined_lcg_shuffled_random.sv
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffled_random
// Two combined multiplicative congruential generators behind a shuffle table.
//
// Input channel (in_valid/in_ready, cmd, seed_value): one transfer asks for
// one draw. cmd 0 takes seed_value as the first-generator value, cmd 1 the
// value kept from the previous draw. A zero or negative value reseeds.
// Output channel (out_valid/out_ready, draw, first_gen_value): one transfer
// per request, in request order.
// An ordinary draw runs multiply, then fold and slot divide, then table
// update, where the result is registered for output; the next request is
// taken after that. A reseed first runs 40 warm-up steps, each a multiply
// and a fold, through the single shared multiply and fold unit.
// The result sits in an output register; the next request is taken and
// worked while it waits, and only the final table update holds until the
// receiver takes the pending result.
// Reset clears the table, the kept values and the output valid flag (draw
// and first_gen_value are not reset), and loads the second generator with its fixed start value.
// ----------------------------------------------------------------------------
module combined_lcg_shuffled_random (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         cmd,
    input  wire logic signed [31:0]           seed_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [clsr_pkg::VAL_W-1:0]        draw,
    output logic [clsr_pkg::VAL_W-1:0]        first_gen_value
);

    clsr_pkg::clsr_cmd_t ctl;
    logic                need_reseed;

    clsr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .need_reseed (need_reseed),
        .ctl         (ctl)
    );

    clsr_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cmd             (cmd),
        .seed_value      (seed_value),
        .need_reseed     (need_reseed),
        .draw            (draw),
        .first_gen_value (first_gen_value)
    );

endmodule
`default_nettype wire
